@@ src/swfs_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swfs_pkg
// Shared types and constants of the square-wave Fourier synthesiser.
// ----------------------------------------------------------------------------
package swfs_pkg;

   localparam int MaxHarmonicsDefault = 64;
   localparam int MaxSamplesDefault   = 4096;

   localparam int IdxW  = 12;
   localparam int CntW  = 13;
   localparam int WavW  = 7;
   localparam int AmpW  = 16;
   localparam int OutW  = 32;

   localparam logic signed [63:0] PiHalfQ30  = 64'sd1686629713;
   localparam logic signed [63:0] FourPiQ30  = 64'sd1367130551;
   localparam logic signed [63:0] OneQ30     = 64'sd1073741824;
   localparam logic signed [63:0] SinP0      = -64'sd209544;
   localparam logic signed [63:0] SinP1      = 64'sd8946590;
   localparam logic signed [63:0] SinP2      = -64'sd178956841;
   localparam logic signed [63:0] CosP0      = 64'sd26235;
   localparam logic signed [63:0] CosP1      = -64'sd1491139;
   localparam logic signed [63:0] CosP2      = 64'sd44739220;

   localparam logic [1:0] RegCount = 2'd0;
   localparam logic [1:0] RegWaves = 2'd1;
   localparam logic [1:0] RegAmp   = 2'd2;

   typedef enum logic [4:0] {
      ST_IDLE, ST_MODM, ST_MODP, ST_PHASE, ST_RED,
      ST_X, ST_Z, ST_P1, ST_P2, ST_P3, ST_P4, ST_P5, ST_FIN,
      ST_TERM, ST_TDIV, ST_ACC, ST_OUT1, ST_OUT2, ST_DONE
   } state_type;

   typedef struct packed {
      logic start;
      logic busy;
   } div_ctl_type;

   // (a*b) >> s with rounding half away from zero; magnitudes fit in 32 bits
   function automatic logic signed [63:0] mul_rnd(input logic signed [63:0] a,
                                                  input logic signed [63:0] b,
                                                  input logic [5:0]         s);
      logic        neg;
      logic [63:0] na, nb, m, half;
      logic [31:0] ma, mb;
      begin
         neg  = a[63] ^ b[63];
         na   = -a;
         nb   = -b;
         ma   = a[63] ? na[31:0] : a[31:0];
         mb   = b[63] ? nb[31:0] : b[31:0];
         m    = {32'd0, ma} * {32'd0, mb};
         half = (s == 6'd0) ? 64'd0 : (64'd1 << (s - 6'd1));
         m    = (m + half) >> s;
         mul_rnd = neg ? -$signed(m) : $signed(m);
      end
   endfunction

endpackage

@@ src/swfs_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swfs_div
// Radix-2 restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module swfs_div
   import swfs_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] dividend,
   input  logic [31:0] divisor,
   output logic        busy,
   output logic [63:0] quotient,
   output logic [31:0] remainder
);
   logic [63:0] q_ff, q_in;
   logic [32:0] r_ff, r_in;
   logic [31:0] d_ff, d_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic [32:0] sh;

   always_comb begin
      q_in   = q_ff;
      r_in   = r_ff;
      d_in   = d_ff;
      cnt_in = cnt_ff;
      sh     = {r_ff[31:0], q_ff[63]};
      if (start) begin
         q_in   = dividend;
         r_in   = '0;
         d_in   = divisor;
         cnt_in = 7'd64;
      end else if (cnt_ff != 7'd0) begin
         // shift in one bit, subtract when it fits
         if (sh >= {1'b0, d_ff}) begin
            r_in = sh - {1'b0, d_ff};
            q_in = {q_ff[62:0], 1'b1};
         end else begin
            r_in = sh;
            q_in = {q_ff[62:0], 1'b0};
         end
         cnt_in = cnt_ff - 7'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
      q_ff <= q_in;
      r_ff <= r_in;
      d_ff <= d_in;
   end

   assign busy      = cnt_ff != 7'd0;
   assign quotient  = q_ff;
   assign remainder = r_ff[31:0];
endmodule

@@ src/square_wave_fourier_synth_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// square_wave_fourier_synth_unit
// Partial Fourier sum of a square wave for one sample index.
// ----------------------------------------------------------------------------
// Use: raise start with req_sample_index while busy is low; the transfer is
// taken at that edge and busy stays high until the result has been shown. The
// result appears for exactly one cycle with rsp_valid high; the receiver
// cannot stall it. Per harmonic the sequencer runs three passes of the shared
// 64-step bit-serial divider (product mod N, phase scaling, division of the
// term by 2k-1), nine products on the shared 32x32 multiplier and a few
// bookkeeping steps, and adds the term to the sum. An index at or beyond N,
// or N of zero, skips the harmonics and goes straight to the result with
// rsp_index_error high and a zero value. The user must write the registers
// through the csr_ APB port only while idle; the unit does not enforce this.
// Reset loads N=1024, 16 waves, A=1.0 and leaves the unit idle.
// ----------------------------------------------------------------------------
module square_wave_fourier_synth_unit
   import swfs_pkg::*;
#(
   parameter int MAX_HARMONICS = MaxHarmonicsDefault,
   parameter int MAX_SAMPLES   = MaxSamplesDefault
)(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  logic [IdxW-1:0]        req_sample_index,
   output logic                   rsp_valid,
   output logic signed [OutW-1:0] rsp_sample_value,
   output logic [IdxW-1:0]        rsp_echo_index,
   output logic                   rsp_clipped,
   output logic                   rsp_index_error,
   input  logic                   csr_psel,
   input  logic                   csr_penable,
   input  logic                   csr_pwrite,
   input  logic [3:0]             csr_paddr,
   input  logic [31:0]            csr_pwdata,
   output logic [31:0]            csr_prdata,
   output logic                   csr_pready
);
   localparam logic [CntW-1:0] NMax = CntW'(MAX_SAMPLES > 8191 ? 8191 : MAX_SAMPLES);
   localparam logic [WavW-1:0] HMax = WavW'(MAX_HARMONICS > 127 ? 127 : MAX_HARMONICS);

   logic [CntW-1:0]        cnt_ff;
   logic [WavW-1:0]        wav_ff;
   logic signed [AmpW-1:0] amp_ff;

   state_type state_ff, state_in;
   logic [IdxW-1:0]  t_ff, t_in;
   logic [CntW-1:0]  n_ff, n_in;
   logic [WavW-1:0]  h_ff, h_in, k_ff, k_in;
   logic signed [63:0] sum_ff, sum_in, x_ff, x_in, z_ff, z_in, y_ff, y_in;
   logic [31:0]      ph_ff, ph_in;
   logic [2:0]       oct_ff, oct_in;
   logic             neg_ff, neg_in, tneg_ff, tneg_in;
   logic             err_ff, err_in;
   logic signed [OutW-1:0] val_ff, val_in;
   logic             clip_ff, clip_in;
   logic             dstart;
   logic [63:0]      dvd;
   logic [31:0]      dvs, drem;
   logic [63:0]      dq;
   logic             dbusy;
   div_ctl_type      dctl;
   logic [7:0]       m;
   logic signed [63:0] mul_a, mul_b, mul_r;
   logic [5:0]       mul_s;
   logic [3:0]       oct_up;
   logic [2:0]       oc;
   logic signed [63:0] r, v;

   swfs_div u_div (
      .clock(clock), .reset(reset), .start(dstart), .dividend(dvd), .divisor(dvs),
      .busy(dbusy), .quotient(dq), .remainder(drem)
   );
   assign dctl = '{start: dstart, busy: dbusy};

   assign csr_pready = 1'b1;
   always_comb begin
      unique case (csr_paddr[3:2])
         RegCount: csr_prdata = {19'd0, cnt_ff};
         RegWaves: csr_prdata = {25'd0, wav_ff};
         RegAmp:   csr_prdata = {{16{amp_ff[15]}}, amp_ff};
         default:  csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= CntW'(1024);
         wav_ff <= WavW'(16);
         amp_ff <= AmpW'(4096);
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
         unique case (csr_paddr[3:2])
            RegCount: cnt_ff <= csr_pwdata[CntW-1:0];
            RegWaves: wav_ff <= csr_pwdata[WavW-1:0];
            RegAmp:   amp_ff <= csr_pwdata[AmpW-1:0];
            default:  ;
         endcase
      end
   end

   // shared multiplier with rounding
   assign mul_r  = mul_rnd(mul_a, mul_b, mul_s);
   assign m      = {k_ff, 1'b0} - 8'd1;
   // octant rounded up to even, may reach eight
   assign oct_up = {1'b0, ph_ff[31:29]} + {3'd0, ph_ff[29]};

   always_comb begin
      state_in = state_ff;
      t_in = t_ff; n_in = n_ff; h_in = h_ff; k_in = k_ff;
      sum_in = sum_ff; x_in = x_ff; z_in = z_ff; y_in = y_ff;
      ph_in = ph_ff; oct_in = oct_ff; neg_in = neg_ff; tneg_in = tneg_ff;
      err_in = err_ff; val_in = val_ff; clip_in = clip_ff;
      dstart = 1'b0; dvd = '0; dvs = 32'd1;
      mul_a = '0; mul_b = '0; mul_s = 6'd1;
      oc = '0; r = '0; v = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               t_in = req_sample_index;
               n_in = (cnt_ff > NMax) ? NMax : cnt_ff;
               h_in = (wav_ff == '0) ? '0 : wav_ff - 1'b1;
               if (h_in > HMax) h_in = HMax;
               k_in = WavW'(1);
               sum_in = '0;
               state_in = ST_MODM;
            end
         end
         ST_MODM: begin
            if (n_ff == '0 || {1'b0, t_ff} >= n_ff) begin
               err_in = 1'b1; val_in = '0; clip_in = 1'b0;
               state_in = ST_DONE;
            end else if (k_ff > h_ff) begin
               err_in = 1'b0;
               state_in = ST_OUT1;
            end else begin
               // (2k-1)*t mod N
               mul_a = 64'(m); mul_b = 64'(t_ff); mul_s = 6'd0;
               dstart = 1'b1;
               dvd = mul_r;
               dvs = 32'(n_ff);
               state_in = ST_MODP;
            end
         end
         ST_MODP: begin
            if (!dbusy) begin
               dstart = 1'b1;
               dvd = {drem, 32'd0};
               dvs = 32'(n_ff);
               state_in = ST_PHASE;
            end
         end
         ST_PHASE: begin
            if (!dbusy) begin
               ph_in = dq[31:0];
               state_in = ST_RED;
            end
         end
         ST_RED: begin
            oc = oct_up[2:0];
            r = $signed({32'd0, ph_ff}) - $signed({31'd0, oct_up, 29'd0});
            neg_in = oc[2];
            oct_in = {1'b0, oc[1:0]};
            x_in = r;
            state_in = ST_X;
         end
         ST_X: begin
            mul_a = x_ff; mul_b = PiHalfQ30; mul_s = 6'd30;
            x_in = mul_r; state_in = ST_Z;
         end
         ST_Z: begin
            mul_a = x_ff; mul_b = x_ff; mul_s = 6'd30;
            z_in = mul_r;
            y_in = (oct_ff == 3'd2) ? CosP0 : SinP0;
            state_in = ST_P1;
         end
         ST_P1: begin
            mul_a = y_ff; mul_b = z_ff; mul_s = 6'd30;
            y_in = mul_r + ((oct_ff == 3'd2) ? CosP1 : SinP1);
            state_in = ST_P2;
         end
         ST_P2: begin
            mul_a = y_ff; mul_b = z_ff; mul_s = 6'd30;
            y_in = mul_r + ((oct_ff == 3'd2) ? CosP2 : SinP2);
            state_in = ST_P3;
         end
         ST_P3: begin
            mul_a = y_ff; mul_b = z_ff; mul_s = 6'd30;
            y_in = mul_r; state_in = ST_P4;
         end
         ST_P4: begin
            mul_a = y_ff; mul_b = (oct_ff == 3'd2) ? z_ff : x_ff; mul_s = 6'd30;
            y_in = mul_r; state_in = ST_P5;
         end
         ST_P5: begin
            mul_a = z_ff; mul_b = 64'sd1; mul_s = 6'd1;
            y_in = (oct_ff == 3'd2) ? y_ff - mul_r + OneQ30 : y_ff + x_ff;
            state_in = ST_FIN;
         end
         ST_FIN: begin
            y_in = neg_ff ? -y_ff : y_ff;
            state_in = ST_TERM;
         end
         ST_TERM: begin
            mul_a = 64'(amp_ff); mul_b = y_ff; mul_s = 6'd0;
            v = mul_r;
            tneg_in = v[63];
            // magnitude plus half divisor, then divide
            dstart = 1'b1;
            dvd = (v[63] ? -v : v) + 64'(m >> 1);
            dvs = 32'(m);
            state_in = ST_TDIV;
         end
         ST_TDIV: begin
            if (!dctl.busy) state_in = ST_ACC;
         end
         ST_ACC: begin
            sum_in = tneg_ff ? sum_ff - $signed(dq) : sum_ff + $signed(dq);
            k_in = k_ff + 1'b1;
            state_in = ST_MODM;
         end
         ST_OUT1: begin
            // round the sum to Q.24, half away from zero
            v = sum_ff[63] ? -sum_ff : sum_ff;
            v = (v + 64'sd131072) >>> 18;
            y_in = sum_ff[63] ? -v : v;
            state_in = ST_OUT2;
         end
         ST_OUT2: begin
            mul_a = y_ff; mul_b = FourPiQ30; mul_s = 6'd38;
            v = mul_r;
            if (v > 64'sd2147483647) begin
               val_in = 32'h7FFFFFFF; clip_in = 1'b1;
            end else if (v < -64'sd2147483648) begin
               val_in = 32'h80000000; clip_in = 1'b1;
            end else begin
               val_in = v[31:0]; clip_in = 1'b0;
            end
            state_in = ST_DONE;
         end
         ST_DONE: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      t_ff <= t_in; n_ff <= n_in; h_ff <= h_in; k_ff <= k_in;
      sum_ff <= sum_in; x_ff <= x_in; z_ff <= z_in; y_ff <= y_in;
      ph_ff <= ph_in; oct_ff <= oct_in; neg_ff <= neg_in; tneg_ff <= tneg_in;
      err_ff <= err_in; val_ff <= val_in; clip_ff <= clip_in;
   end

   assign busy             = state_ff != ST_IDLE;
   assign rsp_valid        = state_ff == ST_DONE;
   assign rsp_sample_value = val_ff;
   assign rsp_echo_index   = t_ff;
   assign rsp_clipped      = clip_ff;
   assign rsp_index_error  = err_ff;
endmodule

@@ src/swfs_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swfs_checker
// Port-level checks of the synthesiser, bound to the top level.
// ----------------------------------------------------------------------------
module swfs_checker
   import swfs_pkg::*;
(
   input logic                   clock,
   input logic                   reset,
   input logic                   start,
   input logic                   busy,
   input logic                   rsp_valid,
   input logic signed [OutW-1:0] rsp_sample_value,
   input logic                   rsp_clipped,
   input logic                   rsp_index_error
);
   // a transfer in makes the unit busy
   a_take: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy) else $error("transfer not taken");
   // a result ends the busy period
   a_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !busy) else $error("busy after result");
   // results come only from a busy unit
   a_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy) else $error("result while idle");
   // an index error result carries zero and is not clipped
   a_err: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_index_error |-> rsp_sample_value == '0 && !rsp_clipped)
      else $error("index error with value");
endmodule

bind square_wave_fourier_synth_unit swfs_checker u_swfs_checker (
   .clock(clock), .reset(reset), .start(start), .busy(busy),
   .rsp_valid(rsp_valid), .rsp_sample_value(rsp_sample_value),
   .rsp_clipped(rsp_clipped), .rsp_index_error(rsp_index_error)
);
